[rtl/mmdp_pkg.sv]
package mmdp_pkg;

    // Widths fixed by the item fields and the register file.
    localparam int CFG_W = 5;
    localparam int IDX_W = 8;
    localparam int VAL_W = 16;
    localparam int RES_W = 32;

    // Command codes.
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SETUP,
        S_MAC,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

[rtl/matrix_multiply_dot_product.sv]
// Matrix multiply, one product component per item. Load items (cmd 0 for A, cmd 1 for B)
// write one Q8.8 element into the on-chip A or B memory and produce no result; a load
// beyond rows * cols of its matrix is dropped. A compute item (cmd 2) names a component of
// C = A * B by its row-major index. The block takes it apart into row and column with a
// restoring divider by b_cols (one quotient bit per cycle), sets up the two memory
// addresses, then streams one A element and one B element per cycle out of the two
// memories into a registered multiplier and a wide accumulator, one pair for each term of
// the inner dimension (a_cols capped at MAX_DIM), and drains that pipeline. Busy then
// stays high until the result strobe, in which busy is low and a new item may already
// be accepted. Compute items that fail their checks (a_cols differing from b_rows, or a
// component index at or beyond a_rows * b_cols) skip the arithmetic and give their result
// in the next cycle with value zero. The result is on the ports for exactly one cycle,
// marked by o_result_strobe, and the receiver cannot hold it off. Elements must be loaded
// before they are used; the memories have no reset. The user must write configuration
// registers through the APB-style port only while the block is idle; the block itself
// does not enforce this.
module matrix_multiply_dot_product #(
    parameter int MAX_DIM    = 16,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Item handshake.
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_cmd,
    input  logic [mmdp_pkg::IDX_W-1:0]          i_elem_index,
    input  logic signed [mmdp_pkg::VAL_W-1:0]   i_elem_value,
    // Result.
    output logic                                o_result_strobe,
    output logic signed [mmdp_pkg::RES_W-1:0]   o_result_value,
    output logic [mmdp_pkg::IDX_W-1:0]          o_result_index,
    output logic [1:0]                          o_status,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int CW     = mmdp_pkg::CFG_W;
    localparam int IW     = mmdp_pkg::IDX_W;
    localparam int PW     = 2 * CW;
    localparam int RB_W   = IW + CW;
    localparam int SW     = (ELEM_WIDTH > 16) ? 16 : ELEM_WIDTH;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int DCW    = $clog2(IW);
    localparam int ACC_RAW = 2 * SW + $clog2(MAX_DIM) + 1;
    localparam int ACC_W  = (ACC_RAW > 33) ? ACC_RAW : 33;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(signed'(32'h7FFF_FFFF));
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(signed'(32'h8000_0000));

    // Dimensions above MAX_DIM are used as MAX_DIM for indexing and range checks.
    function automatic logic [CW-1:0] eff_dim(input logic [CW-1:0] d);
        logic [CW-1:0] r;
        r = (32'(d) > MAX_DIM) ? CW'(MAX_DIM) : d;
        return r;
    endfunction

    // Configuration registers.
    logic [CW-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [CW-1:0] ar_eff, ac_eff, br_eff, bc_eff;

    // Control.
    mmdp_pkg::t_state r_state, n_state;
    logic r_rd_vld, r_mul_vld;
    logic div_en, setup_en, mac_en, div_last, mac_last;
    logic accept, cmp_acc, cfg_wr;

    // Datapath.
    logic [IW-1:0]            r_quo, n_quo;
    logic [CW-1:0]            r_rem, n_rem;
    logic [CW:0]              div_t;
    logic                     div_ge;
    logic [DCW-1:0]           r_div_cnt;
    logic [CW-1:0]            r_j;
    logic [AW-1:0]            r_ai, r_bi;
    logic [RB_W-1:0]          row_base;
    logic signed [SW-1:0]     r_a_q, r_b_q;
    logic signed [2*SW-1:0]   r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [IW-1:0]            r_index;
    logic [1:0]               r_status, n_status;
    logic [PW-1:0]            a_elems, b_elems, c_elems;
    logic                     a_we, b_we;
    logic [AW-1:0]            w_addr;
    logic signed [SW-1:0]     w_data;

    // Element memories, one write and one registered read per cycle each.
    logic signed [SW-1:0] r_mem_a [DEPTH];
    logic signed [SW-1:0] r_mem_b [DEPTH];

    assign ar_eff = eff_dim(r_a_rows);
    assign ac_eff = eff_dim(r_a_cols);
    assign br_eff = eff_dim(r_b_rows);
    assign bc_eff = eff_dim(r_b_cols);

    assign a_elems = PW'(ar_eff) * PW'(ac_eff);
    assign b_elems = PW'(br_eff) * PW'(bc_eff);
    assign c_elems = PW'(ar_eff) * PW'(bc_eff);

    assign accept  = start && !busy;
    assign cmp_acc = accept && (i_cmd == mmdp_pkg::CMD_COMPUTE);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Loads write in the cycle they are accepted. A compute item cannot be in flight then,
    // since busy holds items off for the whole read phase.
    assign a_we   = accept && (i_cmd == mmdp_pkg::CMD_LOAD_A) && (PW'(i_elem_index) < a_elems);
    assign b_we   = accept && (i_cmd == mmdp_pkg::CMD_LOAD_B) && (PW'(i_elem_index) < b_elems);
    assign w_addr = AW'(i_elem_index);
    assign w_data = i_elem_value[SW-1:0];

    // The mismatch test uses the raw register values and wins over the range test.
    always_comb begin
        if (r_a_cols != r_b_rows) begin
            n_status = mmdp_pkg::ST_MISMATCH;
        end else if (PW'(i_elem_index) >= c_elems) begin
            n_status = mmdp_pkg::ST_RANGE;
        end else begin
            n_status = mmdp_pkg::ST_OK;
        end
    end

    // One restoring division step: the dividend shifts in from the top of r_quo.
    assign div_t  = {r_rem, r_quo[IW-1]};
    assign div_ge = div_t >= {1'b0, bc_eff};
    always_comb begin
        n_rem = div_ge ? CW'(div_t - {1'b0, bc_eff}) : div_t[CW-1:0];
        n_quo = {r_quo[IW-2:0], div_ge};
    end

    assign row_base = RB_W'(r_quo) * RB_W'(ac_eff);
    assign div_last = (r_div_cnt == DCW'(IW - 1));
    assign mac_last = (CW'(r_j + CW'(1)) == ac_eff);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mmdp_pkg::S_IDLE, mmdp_pkg::S_DONE: begin
                if (cmp_acc) begin
                    n_state = (n_status == mmdp_pkg::ST_OK) ? mmdp_pkg::S_DIV
                                                            : mmdp_pkg::S_DONE;
                end else begin
                    n_state = mmdp_pkg::S_IDLE;
                end
            end
            mmdp_pkg::S_DIV: begin
                if (div_last) begin
                    n_state = mmdp_pkg::S_SETUP;
                end
            end
            mmdp_pkg::S_SETUP: begin
                n_state = (ac_eff == '0) ? mmdp_pkg::S_DRAIN : mmdp_pkg::S_MAC;
            end
            mmdp_pkg::S_MAC: begin
                if (mac_last) begin
                    n_state = mmdp_pkg::S_DRAIN;
                end
            end
            mmdp_pkg::S_DRAIN: begin
                // The last product is added at the end of the cycle with no read in flight.
                if (!r_rd_vld) begin
                    n_state = mmdp_pkg::S_DONE;
                end
            end
            default: begin
                n_state = mmdp_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        busy            = 1'b1;
        o_result_strobe = 1'b0;
        div_en          = 1'b0;
        setup_en        = 1'b0;
        mac_en          = 1'b0;
        case (r_state)
            mmdp_pkg::S_IDLE: begin
                busy = 1'b0;
            end
            mmdp_pkg::S_DONE: begin
                busy            = 1'b0;
                o_result_strobe = 1'b1;
            end
            mmdp_pkg::S_DIV: begin
                div_en = 1'b1;
            end
            mmdp_pkg::S_SETUP: begin
                setup_en = 1'b1;
            end
            mmdp_pkg::S_MAC: begin
                mac_en = 1'b1;
            end
            mmdp_pkg::S_DRAIN: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mmdp_pkg::S_IDLE;
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
            r_a_rows  <= CW'(1);
            r_a_cols  <= CW'(1);
            r_b_rows  <= CW'(1);
            r_b_cols  <= CW'(1);
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= mac_en;
            r_mul_vld <= r_rd_vld;
            if (cfg_wr) begin
                case (paddr[3:2])
                    mmdp_pkg::REG_A_ROWS: r_a_rows <= pwdata[CW-1:0];
                    mmdp_pkg::REG_A_COLS: r_a_cols <= pwdata[CW-1:0];
                    mmdp_pkg::REG_B_ROWS: r_b_rows <= pwdata[CW-1:0];
                    mmdp_pkg::REG_B_COLS: r_b_cols <= pwdata[CW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (cmp_acc) begin
            r_quo     <= i_elem_index;
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_index   <= i_elem_index;
            r_status  <= n_status;
            r_acc     <= '0;
        end else begin
            if (div_en) begin
                r_quo     <= n_quo;
                r_rem     <= n_rem;
                r_div_cnt <= DCW'(r_div_cnt + DCW'(1));
            end
            if (r_mul_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (setup_en) begin
            // A walks along its row, B walks down its column.
            r_ai <= AW'(row_base);
            r_bi <= AW'(r_rem);
            r_j  <= '0;
        end else if (mac_en) begin
            r_ai <= AW'(r_ai + AW'(1));
            r_bi <= AW'(r_bi + AW'(bc_eff));
            r_j  <= CW'(r_j + CW'(1));
        end
        r_prod <= (2*SW)'(r_a_q) * (2*SW)'(r_b_q);
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_mem_a[w_addr] <= w_data;
        end
        r_a_q <= r_mem_a[r_ai];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_mem_b[w_addr] <= w_data;
        end
        r_b_q <= r_mem_b[r_bi];
    end

    // Result, saturated to Q16.16. Error results carry a cleared accumulator.
    always_comb begin
        if (r_acc > SAT_HI) begin
            o_result_value = signed'(32'h7FFF_FFFF);
        end else if (r_acc < SAT_LO) begin
            o_result_value = signed'(32'h8000_0000);
        end else begin
            o_result_value = signed'(r_acc[31:0]);
        end
    end
    assign o_result_index = r_index;
    assign o_status       = r_status;

    // Register read-back.
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            mmdp_pkg::REG_A_ROWS: prdata = 32'(r_a_rows);
            mmdp_pkg::REG_A_COLS: prdata = 32'(r_a_cols);
            mmdp_pkg::REG_B_ROWS: prdata = 32'(r_b_rows);
            mmdp_pkg::REG_B_COLS: prdata = 32'(r_b_cols);
            default:              prdata = '0;
        endcase
    end

    // A mismatched compute item reports in the very next cycle.
    a_mismatch_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmp_acc && (r_a_cols != r_b_rows))
        |=> (o_result_strobe && (o_status == mmdp_pkg::ST_MISMATCH)))
        else $error("mismatch result not delivered next cycle");

    // Any error result carries value zero.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_status != mmdp_pkg::ST_OK)) |-> (o_result_value == '0))
        else $error("error result with nonzero value");

    // The product pipeline is empty when a result is shown.
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (!r_rd_vld && !r_mul_vld))
        else $error("result shown with products still in flight");

    // A load or unused command never leads to a result.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd != mmdp_pkg::CMD_COMPUTE)) |=> !o_result_strobe)
        else $error("result after a non-compute item");

endmodule
